[hdl/tfzm_pkg.sv]
package tfzm_pkg;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [7:0] NO_TILE    = 8'hFF;
  localparam logic [3:0] FRAC_LIMIT = 4'd8;

  typedef struct packed {
    logic              func;
    logic [5:0]        slot;
    logic [7:0]        cell_x;
    logic [7:0]        cell_y;
    logic [7:0]        zone_kind;
    logic [7:0]        zone_entry;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] zone_type;
    logic [7:0] entry_index;
  } out_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] kind;
    logic [7:0] y;
    logic [7:0] x;
  } entry_t;

  typedef struct packed {
    logic [3:0][7:0] tx;
    logic [3:0][7:0] ty;
  } tiles_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage

[hdl/tile_footprint_zone_match.sv]
// Trigger-zone lookup over a table of tile cells.
// Input: an item transfers at a clock edge with start high and busy low.
//   func = write stores cell_x, cell_y, zone_kind, zone_entry at slot; no
//   result, busy stays low. Slots at or above MAX_ENTRIES are dropped.
//   func = query forms up to four covered 16-pixel tiles from pixel_x and
//   pixel_y and scans entries 0 .. min(entry_count, MAX_ENTRIES)-1 in order.
// Result: valid_o is high for one cycle with result_o (hit, zone_type,
//   entry_index); the receiver cannot hold it off, and the next item may
//   transfer in that same cycle. On a miss the last matched type and index
//   are repeated.
// Scan: with n = min(entry_count, MAX_ENTRIES), one table read per cycle goes
//   through the single memory read port, stopping at the first match or after
//   entry n-1. busy stays high through the scan and falls in the result cycle;
//   a query with n = 0 returns next cycle and keeps busy low.
// Configuration: cfg_we_i writes entry_count from cfg_wdata_i; the user must
//   write it only while idle, which the block itself does not enforce.
// Reset: clears the scan control, entry_count and the last type and index;
//   the table is undefined until written.
module tile_footprint_zone_match #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tfzm_pkg::in_t       item_i,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  output logic                valid_o,
  output tfzm_pkg::out_t      result_o
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [7:0] MaxE = 8'(MAX_ENTRIES);

  logic [6:0]       entry_count_q;
  logic             accept;
  logic             go;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  tfzm_pkg::entry_t wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  tfzm_pkg::entry_t rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= 7'd0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  assign accept  = start && !busy;
  assign go      = accept && (item_i.func == tfzm_pkg::FUNC_QUERY);
  assign wr_en   = accept && (item_i.func == tfzm_pkg::FUNC_WRITE) &&
                   (8'(item_i.slot) < MaxE);
  assign wr_addr = AW'(item_i.slot);
  assign wr_data = '{index: item_i.zone_entry, kind: item_i.zone_kind,
                     y: item_i.cell_y, x: item_i.cell_x};

  tfzm_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  tfzm_scan #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW),
    .CW          (CW)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (go),
    .item_i        (item_i),
    .entry_count_i (entry_count_q),
    .rd_data_i     (rd_data),
    .busy_o        (busy),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .valid_o       (valid_o),
    .result_o      (result_o)
  );

endmodule

[hdl/tfzm_mem.sv]
module tfzm_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  tfzm_pkg::entry_t    wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output tfzm_pkg::entry_t    rdata_o
);

  tfzm_pkg::entry_t mem_q [DEPTH];
  tfzm_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tfzm_match.sv]
module tfzm_match (
  input  tfzm_pkg::entry_t entry_i,
  input  tfzm_pkg::tiles_t tiles_i,
  output logic             match_o
);

  logic [3:0] tile_hit;

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      tile_hit[t] = (tiles_i.tx[t] != tfzm_pkg::NO_TILE) &&
                    (tiles_i.tx[t] == entry_i.x) &&
                    (tiles_i.ty[t] == entry_i.y);
    end
  end

  assign match_o = |tile_hit;

endmodule

[hdl/tfzm_scan.sv]
module tfzm_scan #(
  parameter int MAX_ENTRIES = 64,
  parameter int AW          = 6,
  parameter int CW          = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  tfzm_pkg::in_t    item_i,
  input  logic [6:0]       entry_count_i,
  input  tfzm_pkg::entry_t rd_data_i,
  output logic             busy_o,
  output logic             rd_en_o,
  output logic [AW-1:0]    rd_addr_o,
  output logic             valid_o,
  output tfzm_pkg::out_t   result_o
);

  localparam logic [7:0] MaxE = 8'(MAX_ENTRIES);

  tfzm_pkg::state_e state_q, state_d;
  tfzm_pkg::tiles_t tiles_q, tiles_d, tiles_new;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    n_q, n_d, n_new;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;
  logic             valid_q, valid_d;
  logic             hit_q, hit_d;
  logic [7:0]       last_type_q, last_type_d;
  logic [7:0]       last_index_q, last_index_d;
  logic             match;
  logic             finish;
  logic             issue;
  logic [7:0]       cnt_ext;
  logic [7:0]       bx, by;
  logic             x_frac, y_frac;

  tfzm_match u_match (
    .entry_i (rd_data_i),
    .tiles_i (tiles_q),
    .match_o (match)
  );

  always_comb begin
    bx     = item_i.pixel_x[11:4];
    by     = item_i.pixel_y[11:4];
    x_frac = item_i.pixel_x[3:0] != 4'd0;
    y_frac = item_i.pixel_y[3:0] > tfzm_pkg::FRAC_LIMIT;
    tiles_new.tx[0] = bx;
    tiles_new.ty[0] = by;
    for (int t = 1; t < 4; t++) begin
      tiles_new.tx[t] = tfzm_pkg::NO_TILE;
      tiles_new.ty[t] = tfzm_pkg::NO_TILE;
    end
    if (x_frac) begin
      tiles_new.tx[1] = bx + 8'd1;
      tiles_new.ty[1] = by;
    end
    if (y_frac) begin
      tiles_new.tx[2] = bx;
      tiles_new.ty[2] = by + 8'd1;
      if (x_frac) begin
        tiles_new.tx[3] = bx + 8'd1;
        tiles_new.ty[3] = by + 8'd1;
      end
    end
    cnt_ext = 8'(entry_count_i);
    n_new   = (cnt_ext > MaxE) ? CW'(MaxE) : CW'(cnt_ext);
  end

  assign finish = (state_q == tfzm_pkg::ST_SCAN) && pend_q && (match || pend_last_q);
  assign issue  = (state_q == tfzm_pkg::ST_SCAN) && !finish && (idx_q < n_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tfzm_pkg::ST_IDLE: begin
        if (go_i && (n_new != '0)) begin
          state_d = tfzm_pkg::ST_SCAN;
        end
      end
      tfzm_pkg::ST_SCAN: begin
        if (finish) begin
          state_d = tfzm_pkg::ST_IDLE;
        end
      end
      default: state_d = tfzm_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    tiles_d      = tiles_q;
    n_d          = n_q;
    idx_d        = idx_q;
    pend_d       = 1'b0;
    pend_last_d  = 1'b0;
    valid_d      = 1'b0;
    hit_d        = hit_q;
    last_type_d  = last_type_q;
    last_index_d = last_index_q;
    case (state_q)
      tfzm_pkg::ST_IDLE: begin
        if (go_i) begin
          tiles_d = tiles_new;
          n_d     = n_new;
          idx_d   = '0;
          hit_d   = 1'b0;
          valid_d = (n_new == '0);
        end
      end
      tfzm_pkg::ST_SCAN: begin
        if (finish) begin
          valid_d = 1'b1;
          if (match) begin
            hit_d        = 1'b1;
            last_type_d  = rd_data_i.kind;
            last_index_d = rd_data_i.index;
          end
        end else if (issue) begin
          pend_d      = 1'b1;
          pend_last_d = (idx_q == (n_q - CW'(1)));
          idx_d       = idx_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign busy_o    = (state_q != tfzm_pkg::ST_IDLE);
  assign rd_en_o   = issue;
  assign rd_addr_o = idx_q[AW-1:0];
  assign valid_o   = valid_q;
  assign result_o  = '{hit: hit_q, zone_type: last_type_q, entry_index: last_index_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tfzm_pkg::ST_IDLE;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      pend_last_q  <= 1'b0;
      valid_q      <= 1'b0;
      hit_q        <= 1'b0;
      last_type_q  <= 8'd0;
      last_index_q <= 8'd0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_q       <= pend_d;
      pend_last_q  <= pend_last_d;
      valid_q      <= valid_d;
      hit_q        <= hit_d;
      last_type_q  <= last_type_d;
      last_index_q <= last_index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tiles_q <= tiles_d;
    n_q     <= n_d;
  end

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (state_q == tfzm_pkg::ST_IDLE))
    else $error("result strobe while scanning");

  a_pend_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == tfzm_pkg::ST_SCAN))
    else $error("read pending outside scan");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tfzm_pkg::ST_SCAN) |-> (idx_q <= n_q))
    else $error("scan index beyond entry count");

  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !hit_q) |-> ($stable(last_type_q) && $stable(last_index_q)))
    else $error("last match changed on a miss");

endmodule

[verif/tile_footprint_zone_match_tb.sv]
`timescale 1ns / 1ps

module tile_footprint_zone_match_tb;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned SCAN_SETTLE  = TABLE_DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PHASE_ITEMS  = 140;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  tfzm_pkg::in_t   item_i      = '0;
  logic            cfg_we_i    = 1'b0;
  logic [6:0]      cfg_wdata_i = '0;
  logic            valid_o;
  tfzm_pkg::out_t  result_o;

  tfzm_pkg::in_t    pending_items[$];
  tfzm_pkg::out_t   lookup_expect[$];
  tfzm_pkg::entry_t zone_mem[TABLE_DEPTH];
  logic [7:0]  latched_kind = '0;
  logic [7:0]  latched_rec  = '0;
  logic [6:0]  search_count = '0;
  bit          failed       = 1'b0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 1;
  int unsigned gap_left     = 0;

  tile_footprint_zone_match #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .valid_o    (valid_o),
    .result_o   (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void predict_lookup(tfzm_pkg::in_t it);
    logic [7:0]     tx[4];
    logic [7:0]     ty[4];
    logic [7:0]     bx;
    logic [7:0]     by;
    logic           right;
    logic           lower;
    logic           hit;
    int unsigned    lim;
    tfzm_pkg::out_t res;
    if (it.func == tfzm_pkg::FUNC_WRITE) begin
      zone_mem[it.slot] = '{index: it.zone_entry, kind: it.zone_kind,
                            y: it.cell_y, x: it.cell_x};
      return;
    end
    bx    = it.pixel_x[11:4];
    by    = it.pixel_y[11:4];
    right = (it.pixel_x[3:0] != 4'd0);
    lower = (it.pixel_y[3:0] > tfzm_pkg::FRAC_LIMIT);
    for (int t = 0; t < 4; t++) begin
      tx[t] = tfzm_pkg::NO_TILE;
      ty[t] = tfzm_pkg::NO_TILE;
    end
    tx[0] = bx;
    ty[0] = by;
    if (right) begin
      tx[1] = bx + 8'd1;
      ty[1] = by;
    end
    if (lower) begin
      tx[2] = bx;
      ty[2] = by + 8'd1;
      if (right) begin
        tx[3] = bx + 8'd1;
        ty[3] = by + 8'd1;
      end
    end
    lim = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : 32'(search_count);
    hit = 1'b0;
    for (int unsigned e = 0; e < lim && !hit; e++) begin
      for (int t = 0; t < 4 && !hit; t++) begin
        if (tx[t] != tfzm_pkg::NO_TILE && tx[t] == zone_mem[e].x &&
            ty[t] == zone_mem[e].y) begin
          latched_kind = zone_mem[e].kind;
          latched_rec  = zone_mem[e].index;
          hit = 1'b1;
        end
      end
    end
    res.hit         = hit;
    res.zone_type   = latched_kind;
    res.entry_index = latched_rec;
    lookup_expect.push_back(res);
  endfunction

  function automatic tfzm_pkg::in_t noise_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[70:0];
  endfunction

  function automatic tfzm_pkg::in_t store_item(logic [5:0] s, logic [7:0] x, logic [7:0] y,
                                               logic [7:0] k, logic [7:0] r);
    tfzm_pkg::in_t it;
    it            = noise_item();
    it.func       = tfzm_pkg::FUNC_WRITE;
    it.slot       = s;
    it.cell_x     = x;
    it.cell_y     = y;
    it.zone_kind  = k;
    it.zone_entry = r;
    return it;
  endfunction

  function automatic tfzm_pkg::in_t query_at(logic [15:0] px, logic [15:0] py);
    tfzm_pkg::in_t it;
    it         = noise_item();
    it.func    = tfzm_pkg::FUNC_QUERY;
    it.pixel_x = px;
    it.pixel_y = py;
    return it;
  endfunction

  function automatic tfzm_pkg::in_t random_item(int unsigned lim);
    tfzm_pkg::in_t    it;
    tfzm_pkg::entry_t c;
    logic [7:0]  bx;
    logic [7:0]  by;
    logic        dx;
    logic        dy;
    logic [3:0]  fx;
    logic [3:0]  fy;
    int unsigned roll;
    it   = noise_item();
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      it.func = tfzm_pkg::FUNC_WRITE;
      if (roll < 3) begin
        it.cell_x = tfzm_pkg::NO_TILE;
      end else if (roll < 18) begin
        it.cell_x = 8'($urandom_range(0, 7));
        it.cell_y = 8'($urandom_range(0, 7));
      end
    end else begin
      it.func = tfzm_pkg::FUNC_QUERY;
      if (roll < 85 && lim != 0) begin
        c  = zone_mem[$urandom_range(0, lim - 1)];
        dx = 1'($urandom_range(0, 1));
        dy = 1'($urandom_range(0, 1));
        bx = c.x - 8'(dx);
        by = c.y - 8'(dy);
        fx = dx ? 4'($urandom_range(1, 15)) : 4'($urandom_range(0, 15));
        fy = dy ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 15));
        it.pixel_x = {it.pixel_x[15:12], bx, fx};
        it.pixel_y = {it.pixel_y[15:12], by, fy};
      end else if (roll < 93) begin
        it.pixel_x[11:4] = 8'($urandom_range(0, 8));
        it.pixel_y[11:4] = 8'($urandom_range(0, 8));
      end
    end
    return it;
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || start || lookup_expect.size() != 0);
    repeat (SCAN_SETTLE) @(posedge clk_i);
  endtask

  task automatic set_entry_count(logic [6:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    search_count = v;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_lookup(item_i);
      end
      if (start && busy) begin
        // hold until the scan frees up
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item_i <= pending_items.pop_front();
        start  <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    tfzm_pkg::out_t want;
    if (rst_ni && valid_o) begin
      if (lookup_expect.size() == 0) begin
        failed = 1'b1;
        $display("%0t: result with none pending, expected none, actual %p", $time, result_o);
      end else begin
        want = lookup_expect.pop_front();
        if (result_o.hit !== want.hit) begin
          failed = 1'b1;
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, result_o.hit);
        end
        if (result_o.zone_type !== want.zone_type) begin
          failed = 1'b1;
          $display("%0t: zone_type expected %02h actual %02h",
                   $time, want.zone_type, result_o.zone_type);
        end
        if (result_o.entry_index !== want.entry_index) begin
          failed = 1'b1;
          $display("%0t: entry_index expected %02h actual %02h",
                   $time, want.entry_index, result_o.entry_index);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [6:0] phase_count[10];
    int unsigned lim;
    phase_count = '{7'd64, 7'd127, 7'd1, 7'd65, 7'd0, 7'd8, 7'd16, 7'd63, 7'd3, 7'd40};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // count still at reset: queries miss and report zeros
    pending_items.push_back(query_at(16'h0000, 16'h0000));
    pending_items.push_back(query_at(16'hFFFF, 16'h8000));
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      pending_items.push_back(store_item(6'(s), 8'($urandom_range(0, 7)),
                                         8'($urandom_range(0, 7)),
                                         8'($urandom()), 8'($urandom())));
    end
    wait_idle();

    set_entry_count(7'd4);
    pending_items.push_back(store_item(6'd0, 8'd3, 8'd5, 8'h11, 8'hA0));
    pending_items.push_back(store_item(6'd1, 8'd4, 8'd5, 8'h22, 8'hB1));
    pending_items.push_back(store_item(6'd2, tfzm_pkg::NO_TILE, 8'd7, 8'h33, 8'hC2));
    pending_items.push_back(store_item(6'd3, 8'd0, 8'd0, 8'hFF, 8'hFF));
    pending_items.push_back(query_at(16'h0030, 16'h0050));
    pending_items.push_back(query_at(16'h0040, 16'h0050));
    pending_items.push_back(query_at(16'h0031, 16'h0050));
    pending_items.push_back(query_at(16'h0021, 16'h0059));
    pending_items.push_back(query_at(16'h0030, 16'h0048));
    pending_items.push_back(query_at(16'h0030, 16'h0049));
    pending_items.push_back(query_at(16'h0021, 16'h0049));
    pending_items.push_back(query_at(16'h0FF0, 16'h0070));
    pending_items.push_back(query_at(16'h0FE1, 16'h0070));
    pending_items.push_back(query_at(16'h0FF1, 16'h0000));
    pending_items.push_back(query_at(16'h0000, 16'hFFF9));
    pending_items.push_back(query_at(16'h8000, 16'h7FFF));
    pending_items.push_back(query_at(16'h7FFF, 16'h8000));
    pending_items.push_back(query_at(16'hFFFF, 16'hFFFF));
    pending_items.push_back(query_at(16'h1230, 16'h4560));
    wait_idle();

    foreach (phase_count[p]) begin
      set_entry_count(phase_count[p]);
      lim = (phase_count[p] > TABLE_DEPTH) ? TABLE_DEPTH : 32'(phase_count[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pending_items.push_back(random_item(lim));
      end
      wait_idle();
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
